### sv/sgpm_pkg.sv
// shared constants for the serpentine gamma pixel mapper
// field widths, item kind codes and slot size; no dependencies
package sgpm_pkg;

  localparam int unsigned LEVEL_W     = 8;
  localparam int unsigned INDEX_W     = 8;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned TABLE_DEPTH = 1 << LEVEL_W;
  localparam int unsigned PIXEL_COUNT = 1 << INDEX_W;
  localparam int unsigned BYTES_PER_PIXEL = 3;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 40;

  // item kind carried on tuser
  localparam logic OP_TABLE_LOAD = 1'b0;
  localparam logic OP_PIXEL      = 1'b1;

endpackage

### sv/serpentine_gamma_pixel_mapper.sv
// a pixel beat is registered in the input stage, then its address and gamma reads in the result stage
// one beat per cycle of either kind while the master side does not stall; gamma table loads give no output beat
// the three gamma reads use three copies of the table, each one registered read port
// reset clears the valid flags of both stages only; gamma table contents stay undefined
// until loaded, there is no clearing pass
module serpentine_gamma_pixel_mapper #(
  parameter int unsigned ROWS    = 16,
  parameter int unsigned COLUMNS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // pixel_index, red_level, green_level, blue_level, table_index, table_value
  input  logic [sgpm_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // opcode
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // byte_address, first_byte, second_byte, third_byte, zero fill
  output logic [sgpm_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);
  import sgpm_pkg::*;

  // input stage
  logic               s1_valid_q, s1_valid_d;
  logic               s1_op_q;
  logic [INDEX_W-1:0] s1_pix_q;
  logic [LEVEL_W-1:0] s1_red_q, s1_green_q, s1_blue_q, s1_tidx_q, s1_tval_q;

  // result stage
  logic               s2_valid_q, s2_valid_d;
  logic [ADDR_W-1:0]  s2_addr_q;
  logic [ADDR_W-1:0]  addr_map;
  logic [LEVEL_W-1:0] blue_rd, red_rd, green_rd;

  logic s_accept, s2_free, s1_adv, pix_adv, tbl_we;

  assign s2_free  = !s2_valid_q || m_axis_tready_i;
  assign s1_adv   = s1_valid_q && ((s1_op_q == OP_TABLE_LOAD) || s2_free);
  assign pix_adv  = s1_adv && (s1_op_q == OP_PIXEL);
  assign tbl_we   = s1_adv && (s1_op_q == OP_TABLE_LOAD);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    s1_valid_d = s_accept || (s1_valid_q && !s1_adv);
    s2_valid_d = pix_adv || (s2_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_op_q    <= s_axis_tuser_i;
      s1_pix_q   <= s_axis_tdata_i[7:0];
      s1_red_q   <= s_axis_tdata_i[15:8];
      s1_green_q <= s_axis_tdata_i[23:16];
      s1_blue_q  <= s_axis_tdata_i[31:24];
      s1_tidx_q  <= s_axis_tdata_i[39:32];
      s1_tval_q  <= s_axis_tdata_i[47:40];
    end
    if (pix_adv) begin
      s2_addr_q <= addr_map;
    end
  end

  sgpm_addr_map #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_addr_map (
    .pixel_index_i  (s1_pix_q),
    .byte_address_o (addr_map)
  );

  sgpm_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_gamma_blue (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s1_tidx_q),
    .wdata_i (s1_tval_q),
    .re_i    (pix_adv),
    .raddr_i (s1_blue_q),
    .rdata_o (blue_rd)
  );

  sgpm_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_gamma_red (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s1_tidx_q),
    .wdata_i (s1_tval_q),
    .re_i    (pix_adv),
    .raddr_i (s1_red_q),
    .rdata_o (red_rd)
  );

  sgpm_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_gamma_green (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (s1_tidx_q),
    .wdata_i (s1_tval_q),
    .re_i    (pix_adv),
    .raddr_i (s1_green_q),
    .rdata_o (green_rd)
  );

  assign m_axis_tvalid_o = s2_valid_q;
  assign m_axis_tdata_o  = {6'b0, green_rd, red_rd, blue_rd, s2_addr_q};

`ifndef SYNTHESIS
  // an output beat only ever starts from a pixel leaving the input stage
  a_out_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(pix_adv))
    else $error("output beat without a pixel");

  // a table load never creates an output beat
  a_load_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_we && !s2_valid_q) |=> !s2_valid_q)
    else $error("table load produced an output beat");

  // an empty input stage always takes a beat
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready_o)
    else $error("input stage empty but not ready");
`endif

endmodule

### sv/sgpm_ram.sv
// generic single write port, single read port ram with registered read
// used for the gamma table copies; no dependencies
module sgpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sgpm_addr_map.sv
// serpentine slot address lookup, built at elaboration from the matrix size
// depends on sgpm_pkg
module sgpm_addr_map #(
  parameter int unsigned ROWS    = 16,
  parameter int unsigned COLUMNS = 16
) (
  input  logic [sgpm_pkg::INDEX_W-1:0] pixel_index_i,
  output logic [sgpm_pkg::ADDR_W-1:0]  byte_address_o
);
  import sgpm_pkg::*;

  logic [ADDR_W-1:0] map [PIXEL_COUNT];

  for (genvar i = 0; i < PIXEL_COUNT; i++) begin : g_map
    localparam int unsigned Row = (i / COLUMNS) % ROWS;
    localparam int unsigned Col = i % COLUMNS;
    // odd rows run right to left
    localparam int unsigned Pos = ((Row % 2) == 0) ? Col : (COLUMNS - 1 - Col);
    localparam int unsigned Addr = (Row * COLUMNS + Pos) * BYTES_PER_PIXEL;
    assign map[i] = ADDR_W'(Addr);
  end

  assign byte_address_o = map[pixel_index_i];

endmodule

### tb/tb_serpentine_gamma_pixel_mapper.sv
`timescale 1ns / 1ps
// self-checking bench for serpentine_gamma_pixel_mapper: gamma loads and pixel beats
// with random gaps on both stream sides; depends on sgpm_pkg and the mapper rtl
module tb_serpentine_gamma_pixel_mapper;
  import sgpm_pkg::*;

  localparam int unsigned ROWS    = 16;
  localparam int unsigned COLUMNS = 16;
  localparam int unsigned NUM_RANDOM = 750;

  typedef struct {
    logic       op;
    logic [7:0] pix;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] tbl_idx;
    logic [7:0] tbl_val;
    bit         drain;
  } mapper_item_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [LEVEL_W-1:0] blue_out;
    logic [LEVEL_W-1:0] red_out;
    logic [LEVEL_W-1:0] green_out;
  } led_slot_t;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data  = '0;
  logic                 s_user  = OP_TABLE_LOAD;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;

  serpentine_gamma_pixel_mapper #(
    .ROWS(ROWS),
    .COLUMNS(COLUMNS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data),
    .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data)
  );

  mapper_item_t       mapper_items_q[$];
  led_slot_t          due_slots_q[$];
  logic [LEVEL_W-1:0] gamma_model[TABLE_DEPTH];
  mapper_item_t       cur_item;
  int                 send_idle;
  int                 recv_stall;
  int                 mismatches;
  int                 pixels_sent;
  int                 loads_sent;
  int                 slots_checked;
  bit                 quiet;

  // stimulus-side bookkeeping of which gamma entries hold a value
  bit                 gen_loaded[TABLE_DEPTH];
  int                 loaded_list[$];
  int                 last_loaded;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  assign quiet = mapper_items_q.size() < 100;

  function automatic logic [ADDR_W-1:0] slot_base(logic [INDEX_W-1:0] idx);
    int unsigned row;
    int unsigned col;
    int unsigned pos;
    row = (idx / COLUMNS) % ROWS;
    col = idx % COLUMNS;
    pos = row[0] ? COLUMNS - 1 - col : col;
    return ADDR_W'((row * COLUMNS + pos) * BYTES_PER_PIXEL);
  endfunction

  // advance the gamma table copy and queue the slot a pixel beat must produce
  function automatic void apply_beat(mapper_item_t it);
    led_slot_t slot;
    if (it.op == OP_TABLE_LOAD) begin
      gamma_model[it.tbl_idx] = it.tbl_val;
      loads_sent++;
    end else begin
      slot.addr      = slot_base(it.pix);
      slot.blue_out  = gamma_model[it.blue];
      slot.red_out   = gamma_model[it.red];
      slot.green_out = gamma_model[it.green];
      due_slots_q.push_back(slot);
      pixels_sent++;
    end
  endfunction

  function automatic void add_load(logic [7:0] idx, logic [7:0] val, bit drain);
    mapper_item_t it;
    it.op      = OP_TABLE_LOAD;
    it.pix     = 8'($urandom);
    it.red     = 8'($urandom);
    it.green   = 8'($urandom);
    it.blue    = 8'($urandom);
    it.tbl_idx = idx;
    it.tbl_val = val;
    it.drain   = drain;
    mapper_items_q.push_back(it);
    if (!gen_loaded[idx]) begin
      gen_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    last_loaded = idx;
  endfunction

  function automatic void add_pixel(logic [7:0] pix, logic [7:0] red, logic [7:0] green,
                                    logic [7:0] blue, bit drain);
    mapper_item_t it;
    it.op      = OP_PIXEL;
    it.pix     = pix;
    it.red     = red;
    it.green   = green;
    it.blue    = blue;
    it.tbl_idx = 8'($urandom);
    it.tbl_val = 8'($urandom);
    it.drain   = drain;
    mapper_items_q.push_back(it);
  endfunction

  // only levels whose gamma entry was loaded; often the entry loaded last
  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 3) == 0) return 8'(last_loaded);
    return 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // sender: one beat per handshake, random gaps, optional drain before marked beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid   <= 1'b0;
      s_data    <= '0;
      s_user    <= OP_TABLE_LOAD;
      send_idle = 0;
    end else begin
      if (s_valid && s_ready) apply_beat(cur_item);
      if (!s_valid || s_ready) begin
        if (send_idle > 0) begin
          send_idle--;
          s_valid <= 1'b0;
        end else if (mapper_items_q.size() == 0) begin
          s_valid <= 1'b0;
        end else if (mapper_items_q[0].drain && due_slots_q.size() != 0) begin
          s_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_idle = $urandom_range(1, 8) - 1;
          s_valid <= 1'b0;
        end else begin
          cur_item = mapper_items_q.pop_front();
          s_valid <= 1'b1;
          s_user  <= cur_item.op;
          s_data  <= {cur_item.tbl_val, cur_item.tbl_idx, cur_item.blue,
                      cur_item.green, cur_item.red, cur_item.pix};
        end
      end
    end
  end

  // receiver: check each slot beat against the oldest due slot, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    led_slot_t want;
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      recv_stall = 0;
    end else begin
      if (m_valid && m_ready) begin
        if (due_slots_q.size() == 0) begin
          $display("%0t: unexpected slot beat, expected none actual 0x%0h", $time, m_data);
          mismatches++;
        end else begin
          want = due_slots_q.pop_front();
          check_field("byte_address", want.addr, m_data[9:0]);
          check_field("first_byte", want.blue_out, m_data[17:10]);
          check_field("second_byte", want.red_out, m_data[25:18]);
          check_field("third_byte", want.green_out, m_data[33:26]);
          slots_checked++;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(1, 8) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin
    mismatches    = 0;
    pixels_sent   = 0;
    loads_sent    = 0;
    slots_checked = 0;
    last_loaded   = 0;

    // directed: extreme entries and levels, matrix corners and row turns
    add_load(8'h00, 8'hA5, 1'b0);
    add_load(8'hFF, 8'h5A, 1'b0);
    add_load(8'h55, 8'hFF, 1'b0);
    add_load(8'hAA, 8'h00, 1'b0);
    add_load(8'h01, 8'h01, 1'b0);
    add_load(8'h80, 8'h80, 1'b0);
    add_pixel(8'd0, 8'h00, 8'hFF, 8'h55, 1'b0);
    add_pixel(8'd15, 8'hFF, 8'h00, 8'hAA, 1'b0);
    add_pixel(8'd16, 8'h55, 8'hAA, 8'hFF, 1'b0);
    add_pixel(8'd31, 8'hAA, 8'h55, 8'h00, 1'b0);
    add_pixel(8'd240, 8'h01, 8'h80, 8'hFF, 1'b0);
    add_pixel(8'd255, 8'h80, 8'h01, 8'h00, 1'b0);
    add_pixel(8'd128, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    // rewrite an entry and read it on the very next beat
    add_load(8'h00, 8'h3C, 1'b0);
    add_pixel(8'd17, 8'h00, 8'h00, 8'h00, 1'b0);
    add_load(8'hFF, 8'hC3, 1'b0);
    add_pixel(8'd239, 8'hFF, 8'h00, 8'hFF, 1'b0);
    // hold the sender until the pipeline has drained
    add_pixel(8'd1, 8'h55, 8'hAA, 8'h01, 1'b1);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if ($urandom_range(0, 9) < 3)
        add_load(8'($urandom), 8'($urandom), $urandom_range(0, 149) == 0);
      else
        add_pixel(8'($urandom), pick_level(), pick_level(), pick_level(),
                  $urandom_range(0, 149) == 0);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (mapper_items_q.size() != 0 || s_valid) @(posedge clk_i);
    while (due_slots_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d pixel beats and %0d gamma loads over all rows and both directions",
             pixels_sent, loads_sent);
    $display("checked %0d output slots, %0d field mismatches", slots_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/sgpm_pkg.sv
sv/sgpm_ram.sv
sv/sgpm_addr_map.sv
sv/serpentine_gamma_pixel_mapper.sv
tb/tb_serpentine_gamma_pixel_mapper.sv
